// ===== hw/rtl/rfalu_pkg.sv =====
// Shared types, opcodes and sizes for the register file ALU executor.
package rfalu_pkg;

    localparam int INDEX_BITS = 3;
    localparam int WORD_BITS  = 32;
    localparam int NUM_REGS   = 1 << INDEX_BITS;

    localparam logic [2:0] OP_CMOV = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_NAND = 3'd4;
    localparam logic [2:0] OP_IN   = 3'd5;
    localparam logic [2:0] OP_OUT  = 3'd6;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [INDEX_BITS-1:0] idx_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] reg_a;
        logic [2:0] reg_b;
        logic [2:0] reg_c;
        logic [7:0] in_byte;
        logic       in_eof;
    } instr_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       div_zero;
    } result_t;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hw/rtl/rfalu_if.sv =====
// Valid/ready channel interfaces for instructions and results.
interface rfalu_in_if import rfalu_pkg::*; ();
    logic   valid;
    logic   ready;
    instr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rfalu_out_if import rfalu_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rfalu_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module rfalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== hw/rtl/rfalu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rfalu_div import rfalu_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  word_t     dividend,
    input  word_t     divisor,
    output div_stat_t stat,
    output word_t     quotient
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [CNT_BITS-1:0] cnt_reg;
    logic                done_reg;
    word_t               rem_reg;
    word_t               quo_reg;
    word_t               dvs_reg;
    logic [WORD_BITS:0]  trial;

    assign trial = {rem_reg, quo_reg[WORD_BITS-1]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_BITS'(WORD_BITS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[WORD_BITS])
            begin
                rem_reg <= trial[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[WORD_BITS-2:0], quo_reg[WORD_BITS-1]};
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hw/rtl/register_file_alu_executor_unit.sv =====
// Top level: register file ALU executor with RAM-held registers and iterative divider.
// Executes one instruction at a time against eight 32-bit registers that start at zero.
// The registers live in a two-read-port RAM; a valid bit per register makes a never
// written register read as zero, so no clearing pass is needed after reset. An instruction
// passes through accept, execute and commit steps; its result enters the output register
// at commit, which waits while the output register is still full. A division with a
// nonzero divisor also runs the restoring divider between execute and commit. Every
// instruction gives exactly one result transaction; the next instruction is taken while
// that result still waits to be taken.
module register_file_alu_executor_unit import rfalu_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    rfalu_in_if.sink      instr,
    rfalu_out_if.source   result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [NUM_REGS-1:0] vld_reg;
    instr_t            ins_reg;
    logic              wr_en_reg;
    idx_t              wr_addr_reg;
    word_t             wr_data_reg;
    result_t           res_reg;
    logic              res_vld_reg;
    result_t           pend_reg;

    logic      accept;
    logic      out_free;
    logic      commit;
    idx_t      a_idx;
    idx_t      b_idx;
    idx_t      c_idx;
    word_t     rd_b;
    word_t     rd_c;
    word_t     opb;
    word_t     opc;
    word_t     mul_res;
    word_t     in_word;
    word_t     quotient;
    div_stat_t div_st;
    logic      div_start;

    assign accept   = instr.valid && instr.ready;
    assign out_free = !res_vld_reg || result.ready;
    assign commit   = (state_reg == S_DONE) && out_free;

    assign instr.ready  = (state_reg == S_IDLE);
    assign result.valid = res_vld_reg;
    assign result.data  = res_reg;

    assign a_idx = INDEX_BITS'(ins_reg.reg_a);
    assign b_idx = INDEX_BITS'(ins_reg.reg_b);
    assign c_idx = INDEX_BITS'(ins_reg.reg_c);

    // reads issue from the live payload; data lands in S_EXEC
    rfalu_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .clk    (clk),
        .we     (commit && wr_en_reg),
        .waddr  (wr_addr_reg),
        .wdata  (wr_data_reg),
        .raddr0 (INDEX_BITS'(instr.data.reg_b)),
        .raddr1 (INDEX_BITS'(instr.data.reg_c)),
        .rdata0 (rd_b),
        .rdata1 (rd_c)
    );

    assign opb     = vld_reg[b_idx] ? rd_b : '0;
    assign opc     = vld_reg[c_idx] ? rd_c : '0;
    assign mul_res = opb * opc;
    assign in_word = ins_reg.in_eof ? '1 : {{(WORD_BITS-8){1'b0}}, ins_reg.in_byte};

    assign div_start = (state_reg == S_EXEC) && (ins_reg.cmd == OP_DIV) && (opc != '0);

    rfalu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opb),
        .divisor  (opc),
        .stat     (div_st),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: state_next = div_start ? S_DIV : S_DONE;
            S_DIV:  if (div_st.done) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit && wr_en_reg)
            begin
                vld_reg[wr_addr_reg] <= 1'b1;
            end
            if (commit)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ins_reg <= instr.data;
        end
        if (commit)
        begin
            res_reg <= pend_reg;
        end
        if (state_reg == S_DIV && div_st.done)
        begin
            wr_data_reg <= quotient;
        end
        if (state_reg == S_EXEC)
        begin
            wr_en_reg   <= 1'b0;
            wr_addr_reg <= a_idx;
            wr_data_reg <= '0;
            pend_reg    <= '0;
            case (ins_reg.cmd)
                OP_CMOV:
                begin
                    wr_en_reg   <= (opc != '0);
                    wr_data_reg <= opb;
                end
                OP_ADD:
                begin
                    wr_en_reg   <= 1'b1;
                    wr_data_reg <= opb + opc;
                end
                OP_MUL:
                begin
                    wr_en_reg   <= 1'b1;
                    wr_data_reg <= mul_res;
                end
                OP_DIV:
                begin
                    wr_en_reg         <= (opc != '0);
                    pend_reg.div_zero <= (opc == '0);
                end
                OP_NAND:
                begin
                    wr_en_reg   <= 1'b1;
                    wr_data_reg <= ~(opb & opc);
                end
                OP_IN:
                begin
                    wr_en_reg   <= 1'b1;
                    wr_addr_reg <= c_idx;
                    wr_data_reg <= in_word;
                end
                OP_OUT:
                begin
                    pend_reg.out_byte  <= opc[7:0];
                    pend_reg.out_valid <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted instruction did not move to execute");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> (div_st.busy || div_st.done))
        else $error("divide state with an idle divider");

    a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && pend_reg.div_zero) |-> !wr_en_reg)
        else $error("zero divisor would write the register file");

    a_res_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.out_valid) |-> !result.data.div_zero)
        else $error("output and divide error flagged together");

endmodule

// ===== verif/register_file_alu_executor_unit_tb.sv =====
// Self-checking testbench for the register file ALU executor: directed table plus random run.
`timescale 1ns / 1ps

module register_file_alu_executor_unit_tb import rfalu_pkg::*; ();

    localparam logic [2:0] OP_NONE   = 3'd7;   // unused opcode, no effect
    localparam int RANDOM_ITEMS      = 1700;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES      = 60;
    localparam int MAX_REPORTS       = 10;

    typedef struct {
        instr_t  ins;
        bit      fixed;
        result_t fixed_res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rfalu_in_if  instr_if ();
    rfalu_out_if result_if ();

    register_file_alu_executor_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_if),
        .result (result_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    word_t     gpr [NUM_REGS];
    result_t   predicted_results [$];
    stim_row_t directed_rows [$];
    bit        calm;
    int        errors;
    int        idle_cycles;
    int        n_sent, n_checked, n_out, n_div_zero, n_div_ok, n_eof;

    // Architectural model of one instruction; updates gpr and returns the result.
    function automatic result_t exec_instr(instr_t t);
        result_t r;
        idx_t    a, b, c;
        word_t   vb, vc;
        r  = '0;
        a  = t.reg_a[INDEX_BITS-1:0];
        b  = t.reg_b[INDEX_BITS-1:0];
        c  = t.reg_c[INDEX_BITS-1:0];
        vb = gpr[b];
        vc = gpr[c];
        case (t.cmd)
            OP_CMOV: if (vc != '0) gpr[a] = vb;
            OP_ADD:  gpr[a] = vb + vc;
            OP_MUL:  gpr[a] = vb * vc;
            OP_DIV:
            begin
                if (vc == '0)
                begin
                    r.div_zero = 1'b1;
                    n_div_zero++;
                end
                else
                begin
                    gpr[a] = vb / vc;
                    n_div_ok++;
                end
            end
            OP_NAND: gpr[a] = ~(vb & vc);
            OP_IN:
            begin
                gpr[c] = t.in_eof ? '1 : word_t'(t.in_byte);
                if (t.in_eof) n_eof++;
            end
            OP_OUT:
            begin
                r.out_byte  = vc[7:0];
                r.out_valid = 1'b1;
                n_out++;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic instr_t rand_instr();
        instr_t t;
        int     pick;
        t = '0;
        pick = $urandom_range(0, 99);
        if (pick < 12)      t.cmd = OP_CMOV;
        else if (pick < 26) t.cmd = OP_ADD;
        else if (pick < 40) t.cmd = OP_MUL;
        else if (pick < 55) t.cmd = OP_DIV;
        else if (pick < 65) t.cmd = OP_NAND;
        else if (pick < 80) t.cmd = OP_IN;
        else if (pick < 97) t.cmd = OP_OUT;
        else                t.cmd = OP_NONE;
        t.reg_a   = 3'($urandom_range(0, 7));
        t.reg_b   = 3'($urandom_range(0, 7));
        t.reg_c   = 3'($urandom_range(0, 7));
        t.in_byte = 8'($urandom_range(0, 255));
        t.in_eof  = ($urandom_range(0, 7) == 0);
        return t;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input int a, input int b, input int c,
                           input int byte_val, input bit eof, input bit fixed,
                           input result_t fixed_res);
        stim_row_t row;
        row.ins.cmd     = cmd;
        row.ins.reg_a   = 3'(a);
        row.ins.reg_b   = 3'(b);
        row.ins.reg_c   = 3'(c);
        row.ins.in_byte = 8'(byte_val);
        row.ins.in_eof  = eof;
        row.fixed       = fixed;
        row.fixed_res   = fixed_res;
        directed_rows.push_back(row);
    endtask

    task automatic issue(input instr_t t, input bit fixed, input result_t fixed_res);
        int      gap;
        result_t r;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            instr_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_if.valid <= 1'b1;
        instr_if.data  <= t;
        do @(posedge clk); while (!instr_if.ready);
        r = exec_instr(t);
        predicted_results.push_back(fixed ? fixed_res : r);
        n_sent++;
    endtask

    task automatic note_error(input string what, input int want, input int got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (predicted_results.size() == 0)
        begin
            note_error("unexpected result transaction", 0, int'(got));
            return;
        end
        want = predicted_results.pop_front();
        n_checked++;
        if (got.out_byte !== want.out_byte)
            note_error("out_byte", int'(want.out_byte), int'(got.out_byte));
        if (got.out_valid !== want.out_valid)
            note_error("out_valid", int'(want.out_valid), int'(got.out_valid));
        if (got.div_zero !== want.div_zero)
            note_error("div_zero", int'(want.div_zero), int'(got.div_zero));
    endtask

    // result side: random stalls, checks every accepted transaction
    initial
    begin
        int gap;
        result_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
            check_result(result_if.data);
        end
    end

    // cycles without any transaction on either channel
    always @(posedge clk)
    begin
        if ((instr_if.valid && instr_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, predicted_results.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        result_t none, zero_out, ff_out, dz;
        none     = '0;
        zero_out = '{out_byte: 8'h00, out_valid: 1'b1, div_zero: 1'b0};
        ff_out   = '{out_byte: 8'hFF, out_valid: 1'b1, div_zero: 1'b0};
        dz       = '{out_byte: 8'h00, out_valid: 1'b0, div_zero: 1'b1};

        instr_if.valid <= 1'b0;
        instr_if.data  <= '0;
        calm        = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        foreach (gpr[i]) gpr[i] = '0;

        // registers read zero after reset
        add_row(OP_OUT,  0, 0, 0, 8'h00, 1'b0, 1'b1, zero_out);
        add_row(OP_DIV,  1, 2, 3, 8'h00, 1'b0, 1'b1, dz);
        // end of input loads all ones, byte ignored
        add_row(OP_IN,   0, 0, 1, 8'h5A, 1'b1, 1'b1, none);
        add_row(OP_OUT,  0, 0, 1, 8'h00, 1'b0, 1'b1, ff_out);
        add_row(OP_IN,   7, 7, 2, 8'hFF, 1'b0, 1'b1, none);
        add_row(OP_IN,   0, 0, 3, 8'h00, 1'b0, 1'b1, none);
        add_row(OP_CMOV, 4, 1, 3, 8'h00, 1'b0, 1'b0, none);   // zero condition, no move
        add_row(OP_OUT,  0, 0, 4, 8'h00, 1'b0, 1'b1, zero_out);
        add_row(OP_CMOV, 4, 1, 2, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_ADD,  5, 1, 1, 8'h00, 1'b0, 1'b0, none);   // wraps
        add_row(OP_OUT,  0, 0, 5, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_MUL,  6, 1, 1, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_NAND, 7, 1, 1, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_NAND, 7, 3, 3, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_DIV,  0, 1, 2, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_DIV,  3, 2, 1, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_DIV,  3, 1, 1, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_NONE, 0, 1, 2, 8'hFF, 1'b1, 1'b1, none);
        add_row(OP_OUT,  0, 0, 0, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_IN,   0, 0, 7, 8'hAA, 1'b0, 1'b1, none);
        add_row(OP_OUT,  7, 7, 7, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_MUL,  2, 0, 7, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_DIV,  7, 7, 7, 8'h00, 1'b0, 1'b0, none);
        add_row(OP_OUT,  0, 0, 6, 8'h00, 1'b0, 1'b0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].ins, directed_rows[i].fixed, directed_rows[i].fixed_res);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // every fourth stretch of 200 runs back to back on both sides
            calm = ((i / 200) % 4 == 3);
            if (i == RANDOM_ITEMS / 2)
            begin
                instr_if.valid <= 1'b0;
                wait (predicted_results.size() == 0);
                @(posedge clk);
            end
            issue(rand_instr(), 1'b0, none);
        end
        instr_if.valid <= 1'b0;

        wait (predicted_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
            note_error("results still outstanding", 0, predicted_results.size());

        $display("run covered %0d instructions, %0d results checked, %0d mismatches",
                 n_sent, n_checked, errors);
        $display("  %0d outputs, %0d divisions, %0d zero divisors, %0d end-of-input loads",
                 n_out, n_div_ok + n_div_zero, n_div_zero, n_eof);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
